// ----- hdl/ppad_pkg.sv -----
package ppad_pkg;

  localparam int unsigned LANES      = 64;
  localparam int unsigned MAX_POINTS = 16;
  localparam int unsigned LANE_W     = 6;
  localparam int unsigned VTX_W      = 4;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned ADDR_W     = LANE_W + VTX_W;
  localparam int unsigned DEPTH      = LANES * MAX_POINTS;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] STAT_INTERP = 2'd0;
  localparam logic [1:0] STAT_CLAMP  = 2'd1;
  localparam logic [1:0] STAT_EMPTY  = 2'd2;

  typedef struct packed {
    logic               op;
    logic [5:0]         lane_index;
    logic [3:0]         vertex_index;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic               is_last_vertex;
    logic [31:0]        distance;
  } ppad_in_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [1:0]         status;
  } ppad_out_t;

endpackage

// ----- hdl/polyline_point_at_distance_top.sv -----
// Polyline point at distance. A write transaction (op = write) stores one vertex of one
// lane; with is_last_vertex it also sets the lane vertex count. A query transaction
// returns one result: the point at the given arc length along the lane, the last vertex
// if the distance runs past the end, or the origin for an empty lane. A query reads the
// lane count, then walks the segments one at a time: per segment it reads the two
// vertices, forms and squares the differences, runs the 33-step square root and
// compares; on the segment that holds the point it then runs the interpolation divider
// and the coordinate multiplies. busy stays high while a query runs, and res_valid_o
// rises as busy falls. The result strobe res_valid_o is high for exactly one cycle and
// the receiver cannot stall it, so it must take every result when it appears.
module polyline_point_at_distance_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  ppad_pkg::ppad_in_t in_i,
  output logic               res_valid_o,
  output ppad_pkg::ppad_out_t res_o
);
  import ppad_pkg::*;

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CNT  = 4'd1;
  localparam logic [3:0] S_RA   = 4'd2;
  localparam logic [3:0] S_RB   = 4'd3;
  localparam logic [3:0] S_DIFF = 4'd4;
  localparam logic [3:0] S_SQX  = 4'd5;
  localparam logic [3:0] S_SQY  = 4'd6;
  localparam logic [3:0] S_SUM  = 4'd7;
  localparam logic [3:0] S_SQRT = 4'd8;
  localparam logic [3:0] S_CMP  = 4'd9;
  localparam logic [3:0] S_DIV  = 4'd10;
  localparam logic [3:0] S_MX   = 4'd11;
  localparam logic [3:0] S_MY   = 4'd12;
  localparam logic [3:0] S_MO   = 4'd13;
  localparam logic [3:0] S_LA   = 4'd14;
  localparam logic [3:0] S_LB   = 4'd15;

  logic [3:0] state_q, state_d;

  // vertex store, x in the upper half and y in the lower half
  logic [63:0]       vmem [DEPTH];
  logic [63:0]       vd_q;
  logic [ADDR_W-1:0] raddr;
  logic [VTX_W-1:0]  ridx;

  // lane vertex counts with per-lane valid bits
  logic [CNT_W-1:0]  cmem [LANES];
  logic [CNT_W-1:0]  crd_q;
  logic [LANES-1:0]  cvalid_q;

  // query context
  logic [LANE_W-1:0] lane_q;
  logic [31:0]       dist_q, seen_q;
  logic [CNT_W-1:0]  cnt_q, k_q;
  logic [31:0]       x0_q, y0_q, ax_q, ay_q;
  logic              nx_q, ny_q;
  logic [63:0]       sx_q;
  logic [32:0]       len_q, f_q;
  logic [31:0]       px_q;

  // segment difference
  logic [32:0] dx, dy, dxn, dyn;
  logic [33:0] seg_sum;
  logic [64:0] sq_sum;
  logic [31:0] delta;
  logic [CNT_W-1:0] k_inc;

  // shared units
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic        sq_start, sq_done, dv_start, dv_done;
  logic [32:0] sq_root, dv_quo;

  logic      accept, out_valid_q;
  ppad_out_t out_q;

  assign accept = start && !busy;
  assign busy   = state_q != S_IDLE;

  ppad_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  ppad_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i ({1'b0, sq_sum}),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  ppad_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start),
    .num_i   (dist_q - seen_q),
    .den_i   (len_q),
    .done_o  (dv_done),
    .quo_o   (dv_quo)
  );

  // end vertex minus start vertex, sign-extended
  assign dx  = {vd_q[63], vd_q[63:32]} - {x0_q[31], x0_q};
  assign dy  = {vd_q[31], vd_q[31:0]} - {y0_q[31], y0_q};
  assign dxn = -dx;
  assign dyn = -dy;

  assign sq_sum  = {1'b0, sx_q} + {1'b0, mul_p};
  assign seg_sum = {2'b00, seen_q} + {1'b0, len_q};
  assign k_inc   = k_q + CNT_W'(1);
  // full fraction means the whole segment difference
  assign delta   = f_q[32] ? ((state_q == S_MY) ? ax_q : ay_q) : mul_p[63:32];

  // read index per state
  always_comb begin
    case (state_q)
      S_RA:    ridx = VTX_W'(k_q - CNT_W'(1));
      S_RB:    ridx = VTX_W'(k_q);
      default: ridx = VTX_W'(cnt_q - CNT_W'(1));
    endcase
  end
  assign raddr = {lane_q, ridx};

  always_comb begin
    case (state_q)
      S_SQY:   begin mul_a = ay_q; mul_b = ay_q;       end
      S_MX:    begin mul_a = ax_q; mul_b = f_q[31:0];  end
      S_MY:    begin mul_a = ay_q; mul_b = f_q[31:0];  end
      default: begin mul_a = ax_q; mul_b = ax_q;       end
    endcase
  end

  assign sq_start = state_q == S_SUM;
  assign dv_start = (state_q == S_CMP) && (seg_sum >= {2'b00, dist_q}) && (len_q != 33'd0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept && in_i.op == OP_QUERY) state_d = S_CNT;
      S_CNT: begin
        if (!cvalid_q[lane_q] || crd_q == CNT_W'(0)) state_d = S_IDLE;
        else if (crd_q == CNT_W'(1))                 state_d = S_LA;
        else                                         state_d = S_RA;
      end
      S_RA:   state_d = S_RB;
      S_RB:   state_d = S_DIFF;
      S_DIFF: state_d = S_SQX;
      S_SQX:  state_d = S_SQY;
      S_SQY:  state_d = S_SUM;
      S_SUM:  state_d = S_SQRT;
      S_SQRT: if (sq_done) state_d = S_CMP;
      S_CMP: begin
        if (seg_sum < {2'b00, dist_q}) state_d = (k_inc == cnt_q) ? S_LA : S_RA;
        else if (len_q == 33'd0)      state_d = S_IDLE;
        else                          state_d = S_DIV;
      end
      S_DIV:  if (dv_done) state_d = S_MX;
      S_MX:   state_d = S_MY;
      S_MY:   state_d = S_MO;
      S_MO:   state_d = S_IDLE;
      S_LA:   state_d = S_LB;
      S_LB:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cvalid_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= 1'b0;
      if (accept && in_i.op == OP_WRITE && in_i.is_last_vertex) begin
        cvalid_q[in_i.lane_index] <= 1'b1;
      end
      if (state_q == S_CNT && (!cvalid_q[lane_q] || crd_q == CNT_W'(0))) out_valid_q <= 1'b1;
      if (state_q == S_CMP && seg_sum >= {2'b00, dist_q} && len_q == 33'd0) begin
        out_valid_q <= 1'b1;
      end
      if (state_q == S_MO || state_q == S_LB) out_valid_q <= 1'b1;
    end
  end

  // stores
  always_ff @(posedge clk_i) begin
    if (accept && in_i.op == OP_WRITE) begin
      vmem[{in_i.lane_index, in_i.vertex_index}] <= {in_i.vertex_x, in_i.vertex_y};
      if (in_i.is_last_vertex) begin
        cmem[in_i.lane_index] <= CNT_W'(in_i.vertex_index) + CNT_W'(1);
      end
    end
    vd_q  <= vmem[raddr];
    crd_q <= cmem[in_i.lane_index];
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        lane_q <= in_i.lane_index;
        dist_q <= in_i.distance;
        seen_q <= 32'd0;
        k_q    <= CNT_W'(1);
      end
      S_CNT: begin
        cnt_q <= crd_q;
        out_q <= '{point_x: '0, point_y: '0, status: STAT_EMPTY};
      end
      S_RB: begin
        x0_q <= vd_q[63:32];
        y0_q <= vd_q[31:0];
      end
      S_DIFF: begin
        nx_q <= dx[32];
        ny_q <= dy[32];
        ax_q <= dx[32] ? dxn[31:0] : dx[31:0];
        ay_q <= dy[32] ? dyn[31:0] : dy[31:0];
      end
      S_SQY: sx_q <= mul_p;
      S_SQRT: if (sq_done) len_q <= sq_root;
      S_CMP: begin
        if (seg_sum < {2'b00, dist_q}) begin
          seen_q <= seg_sum[31:0];
          k_q    <= k_inc;
        end
        out_q <= '{point_x: x0_q, point_y: y0_q, status: STAT_INTERP};
      end
      S_DIV: if (dv_done) f_q <= dv_quo;
      S_MY: px_q <= nx_q ? (x0_q - delta) : (x0_q + delta);
      S_MO: out_q <= '{point_x: px_q,
                       point_y: ny_q ? (y0_q - delta) : (y0_q + delta),
                       status: STAT_INTERP};
      S_LB: out_q <= '{point_x: vd_q[63:32], point_y: vd_q[31:0], status: STAT_CLAMP};
      default: ;
    endcase
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  // a result only appears once the sequencer is back at rest
  a_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> state_q == S_IDLE)
    else $error("result strobe outside idle");

  // square root completion only while the sequencer waits for it
  a_sq_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> state_q == S_SQRT)
    else $error("square root done in wrong state");

  // divider completion only while the sequencer waits for it
  a_dv_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_done |-> state_q == S_DIV)
    else $error("divider done in wrong state");

  // status code is always one of the defined values
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> res_o.status != 2'd3)
    else $error("bad status code");

  // a query accept always moves the sequencer off idle
  a_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.op == OP_QUERY) |=> state_q == S_CNT)
    else $error("query not started");
endmodule

// ----- hdl/ppad_mul.sv -----
module ppad_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);
  logic [63:0] p_q;

  // registered 32x32 product
  always_ff @(posedge clk_i) begin
    p_q <= {32'd0, a_i} * {32'd0, b_i};
  end

  assign p_o = p_q;
endmodule

// ----- hdl/ppad_sqrt.sv -----
module ppad_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [65:0] radicand_i,
  output logic        done_o,
  output logic [32:0] root_o
);
  logic [65:0] val_q;
  logic [35:0] rem_q, rem_sh, test;
  logic [32:0] root_q;
  logic [5:0]  cnt_q;
  logic        run_q, done_q, ge;

  // one radicand bit pair per cycle
  assign rem_sh = {rem_q[33:0], val_q[65:64]};
  assign test   = {1'b0, root_q, 2'b01};
  assign ge     = rem_sh >= test;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= 6'd32;
      end else if (run_q) begin
        if (cnt_q == 6'd0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= radicand_i;
      rem_q  <= 36'd0;
      root_q <= 33'd0;
    end else if (run_q) begin
      val_q  <= {val_q[63:0], 2'b00};
      rem_q  <= ge ? (rem_sh - test) : rem_sh;
      root_q <= {root_q[31:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule

// ----- hdl/ppad_div.sv -----
module ppad_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [32:0] den_i,
  output logic        done_o,
  output logic [32:0] quo_o
);
  logic [33:0] rem_q, diff, rem_sel;
  logic [32:0] den_q, q_q;
  logic [5:0]  cnt_q;
  logic        run_q, done_q, ge;

  // restoring division of num * 2^32 by den, one quotient bit per cycle
  assign diff    = rem_q - {1'b0, den_q};
  assign ge      = rem_q >= {1'b0, den_q};
  assign rem_sel = ge ? diff : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= 6'd32;
      end else if (run_q) begin
        if (cnt_q == 6'd0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {2'b00, num_i};
      den_q <= den_i;
      q_q   <= 33'd0;
    end else if (run_q) begin
      rem_q <= {rem_sel[32:0], 1'b0};
      q_q   <= {q_q[31:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = q_q;
endmodule
